### hw/rtl/rwss_pkg.sv
package rwss_pkg;

	localparam int MAX_MEMBERS = 8;
	localparam int IDX_W = $clog2(MAX_MEMBERS);
	localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

	localparam logic [31:0] RTT_NONE = 32'hFFFF_FFFF;
	localparam logic [15:0] RUN_MAX = 16'hFFFF;
	localparam logic [15:0] THRESH_RESET = 16'd3;
	localparam logic [31:0] HOLD_RESET = 32'd30000;

	typedef enum logic [1:0] {
		CMD_SELECT = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_FAIL   = 2'd2,
		CMD_PROBE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_COUNT  = 2'd0,
		CFG_THRESH = 2'd1,
		CFG_HOLD   = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// Table update broadcast to every cell
	typedef struct packed {
		logic              sample;
		logic              fail;
		logic [IDX_W-1:0]  member;
		logic [31:0]       rtt;
		logic [31:0]       now;
		logic [15:0]       thresh;
		logic [31:0]       hold;
	} upd_t;

	// Scan context held steady while the wave runs
	typedef struct packed {
		logic [IDX_W:0]    skip;
		logic [31:0]       now;
		logic [CNT_W-1:0]  count;
	} scan_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [31:0]       rtt;
	} lane_t;

	// Running minima: hold honored, avoid only, no skip
	typedef struct packed {
		lane_t             best_hold;
		lane_t             best_free;
		lane_t             best_all;
	} carry_t;

	// Cursor modulo count by repeated compare and subtract
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] c,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] v;
		v = CNT_W'(c);
		for (int k = 0; k < MAX_MEMBERS; k++) begin
			if (n != '0 && v >= n) begin
				v = v - n;
			end
		end
		if (n == '0) begin
			v = '0;
		end
		return v[IDX_W-1:0];
	endfunction

endpackage

### hw/rtl/rwss_cell.sv
module rwss_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rwss_pkg::IDX_W-1:0]      cell_idx,
	input  rwss_pkg::upd_t                  upd,
	input  rwss_pkg::scan_t                 scan,
	input  rwss_pkg::carry_t                carry_in,
	output rwss_pkg::carry_t                carry_out_q
);

	logic [31:0] srtt_q;
	logic [15:0] run_q;
	logic        hold_q;
	logic [31:0] until_q;

	logic        hit;
	logic [15:0] run_inc;
	logic [31:0] srtt_next;
	logic [31:0] hold_diff;
	logic        active;
	logic        skipped;
	logic        in_service;
	rwss_pkg::carry_t carry_next;

	// Table update for this server
	assign hit = (upd.member == cell_idx);
	assign run_inc = (run_q == rwss_pkg::RUN_MAX) ? run_q : run_q + 16'd1;
	assign srtt_next = (srtt_q == rwss_pkg::RTT_NONE) ? upd.rtt
		: srtt_q - (srtt_q >> 3) + (upd.rtt >> 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q  <= rwss_pkg::RTT_NONE;
			run_q   <= '0;
			hold_q  <= 1'b0;
			until_q <= '0;
		end else if (hit && upd.sample) begin
			srtt_q <= srtt_next;
			run_q  <= '0;
			hold_q <= 1'b0;
		end else if (hit && upd.fail) begin
			run_q <= run_inc;
			if (run_inc >= upd.thresh) begin
				hold_q  <= 1'b1;
				until_q <= upd.now + upd.hold;
			end
		end
	end

	// Eligibility for each of the three minima
	assign hold_diff = scan.now - until_q;
	assign in_service = !hold_q || !hold_diff[31];
	assign active = (rwss_pkg::CNT_W'(cell_idx) < scan.count);
	assign skipped = ({1'b0, cell_idx} == scan.skip);

	always_comb begin
		carry_next = carry_in;
		if (active && !skipped && in_service
				&& (!carry_in.best_hold.found || srtt_q < carry_in.best_hold.rtt)) begin
			carry_next.best_hold = '{found: 1'b1, idx: cell_idx, rtt: srtt_q};
		end
		if (active && !skipped
				&& (!carry_in.best_free.found || srtt_q < carry_in.best_free.rtt)) begin
			carry_next.best_free = '{found: 1'b1, idx: cell_idx, rtt: srtt_q};
		end
		if (active
				&& (!carry_in.best_all.found || srtt_q < carry_in.best_all.rtt)) begin
			carry_next.best_all = '{found: 1'b1, idx: cell_idx, rtt: srtt_q};
		end
	end

	// Hand the minima to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_out_q <= '0;
		end else begin
			carry_out_q <= carry_next;
		end
	end

endmodule

### hw/rtl/rtt_weighted_server_selector.sv
// Server selector with RTT smoothing and failure hold-down.
// Input: start with cmd, member, avoid, rtt_ms, now_ms; a command is taken
// at a rising edge with start high and busy low.
// Sample and failure commands update the table at that edge and give no
// result; busy stays low, so they may follow each other every cycle.
// Select and probe-pick commands launch a scan wave down the row of eight
// server cells, one cell per cycle, carrying three running minima. The
// answer (chosen, found, kind) appears with done high for one cycle
// as busy falls; busy is high while the wave runs.
// Configuration: wr_en, wr_index, wr_data write member_count, down_threshold and
// hold_ms; the user must write only while the block is idle, which the block does not enforce.
// Reset (arst_n low) marks every server unmeasured, clears failure runs,
// holds and the probe cursor, and loads the register defaults.
// The receiver cannot stall: done is a one-cycle strobe and must be taken.
module rtt_weighted_server_selector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [2:0]  member,
	input  logic [3:0]  avoid,
	input  logic [31:0] rtt_ms,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [2:0]  chosen,
	output logic        found,
	output logic        kind,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int IDX_W = rwss_pkg::IDX_W;
	localparam int CNT_W = rwss_pkg::CNT_W;
	localparam int MAXM = rwss_pkg::MAX_MEMBERS;

	logic [3:0]  count_q;
	logic [15:0] thresh_q;
	logic [31:0] hold_q;

	rwss_pkg::state_t state_q, state_next;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] live;
	logic             take;
	logic             scan_end;
	logic             launch;

	rwss_pkg::scan_t  scan_q;
	logic             kind_q;
	logic [IDX_W-1:0] cursor_q;
	logic [IDX_W-1:0] start_q;

	rwss_pkg::upd_t   upd;
	rwss_pkg::carry_t chain [MAXM+1];

	logic             done_q;
	logic [2:0]       chosen_q;
	logic             found_q;
	logic             kindo_q;

	logic             sel_found;
	logic [IDX_W-1:0] sel_idx;
	logic [CNT_W-1:0] start_inc;
	logic [IDX_W-1:0] cand;
	logic             cand_ok;
	logic [CNT_W-1:0] cand_inc;
	logic [IDX_W-1:0] cursor_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			thresh_q <= rwss_pkg::THRESH_RESET;
			hold_q   <= rwss_pkg::HOLD_RESET;
		end else if (wr_en) begin
			unique case (rwss_pkg::cfg_idx_t'(wr_index))
				rwss_pkg::CFG_COUNT:  count_q  <= wr_data[3:0];
				rwss_pkg::CFG_THRESH: thresh_q <= wr_data[15:0];
				rwss_pkg::CFG_HOLD:   hold_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign live = (count_q > 4'(MAXM)) ? CNT_W'(MAXM) : CNT_W'(count_q);

	// Command decode
	assign take = start && !busy;
	assign launch = take && (rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_SELECT
		|| rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_PROBE);

	always_comb begin
		upd.sample = take && (rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_SAMPLE)
			&& (CNT_W'(member) < live);
		upd.fail = take && (rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_FAIL)
			&& (CNT_W'(member) < live);
		upd.member = IDX_W'(member);
		upd.rtt = rtt_ms;
		upd.now = now_ms;
		upd.thresh = thresh_q;
		upd.hold = hold_q;
	end

	// Sequencer: next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rwss_pkg::ST_IDLE: if (launch) state_next = rwss_pkg::ST_SCAN;
			rwss_pkg::ST_SCAN: if (scan_end) state_next = rwss_pkg::ST_IDLE;
			default: state_next = rwss_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		busy = 1'b0;
		scan_end = 1'b0;
		unique case (state_q)
			rwss_pkg::ST_IDLE: busy = 1'b0;
			rwss_pkg::ST_SCAN: begin
				busy = 1'b1;
				scan_end = (step_q == CNT_W'(MAXM));
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwss_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (launch) begin
				step_q <= '0;
			end else if (busy) begin
				step_q <= step_q + CNT_W'(1);
			end
		end
	end

	// Latch the scan context
	always_ff @(posedge clk) begin
		if (launch) begin
			scan_q.now   <= now_ms;
			scan_q.count <= live;
			scan_q.skip  <= (rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_PROBE || avoid[3])
				? (IDX_W+1)'(MAXM) : (IDX_W+1)'(avoid[2:0]);
			kind_q  <= (rwss_pkg::cmd_t'(cmd) == rwss_pkg::CMD_PROBE);
			start_q <= rwss_pkg::wrap_idx(cursor_q, live);
		end
	end

	// Row of server cells
	assign chain[0] = '0;

	for (genvar g = 0; g < MAXM; g++) begin : g_cell
		rwss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (IDX_W'(g)),
			.upd         (upd),
			.scan        (scan_q),
			.carry_in    (chain[g]),
			.carry_out_q (chain[g+1])
		);
	end

	// Pick the first pass that found a server
	always_comb begin
		priority if (chain[MAXM].best_hold.found) begin
			sel_found = 1'b1;
			sel_idx = chain[MAXM].best_hold.idx;
		end else if (chain[MAXM].best_free.found) begin
			sel_found = 1'b1;
			sel_idx = chain[MAXM].best_free.idx;
		end else begin
			sel_found = chain[MAXM].best_all.found;
			sel_idx = chain[MAXM].best_all.idx;
		end
	end

	// Round-robin probe target: cursor, or the next one if that is selected
	assign start_inc = CNT_W'(start_q) + CNT_W'(1);
	assign cand = (start_q != sel_idx) ? start_q
		: ((start_inc == scan_q.count) ? '0 : start_inc[IDX_W-1:0]);
	assign cand_ok = (scan_q.count != '0) && (cand != sel_idx);
	assign cand_inc = CNT_W'(cand) + CNT_W'(1);
	assign cursor_next = (cand_inc == scan_q.count) ? '0 : cand_inc[IDX_W-1:0];

	// Result and probe cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			cursor_q <= '0;
		end else begin
			done_q <= scan_end;
			if (scan_end && kind_q && cand_ok) begin
				cursor_q <= cursor_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			kindo_q <= kind_q;
			if (kind_q) begin
				found_q  <= cand_ok;
				chosen_q <= cand_ok ? 3'(cand) : 3'd0;
			end else begin
				found_q  <= sel_found;
				chosen_q <= sel_found ? 3'(sel_idx) : 3'd0;
			end
		end
	end

	assign done = done_q;
	assign chosen = chosen_q;
	assign found = found_q;
	assign kind = kindo_q;

endmodule
